@@ hw/rtl/ffa_pkg.sv @@
// shared constants, codes and types of the first-fit allocator
package ffa_pkg;

    // fixed field widths of the transaction channels
    localparam int SIZE_W     = 16;
    localparam int REQ_W      = 11;
    localparam int ADDR_OUT_W = 16;

    // defaults for the top level parameters
    localparam int DEF_MAX_FREE_BLOCKS = 256;
    localparam int DEF_MAX_REQUESTS    = 1024;
    localparam int DEF_ADDR_BITS       = 16;

    // memory size after reset
    localparam logic [SIZE_W-1:0] RESET_MEMORY_SIZE = 16'hFFFF;

    // function codes of an input transaction
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // cell update operations
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_INIT       = 3'd1;
    localparam logic [2:0] OP_SHRINK     = 3'd2;
    localparam logic [2:0] OP_REMOVE     = 3'd3;
    localparam logic [2:0] OP_MERGE_BOTH = 3'd4;
    localparam logic [2:0] OP_MERGE_PREV = 3'd5;
    localparam logic [2:0] OP_MERGE_NEXT = 3'd6;
    localparam logic [2:0] OP_INSERT     = 3'd7;

    // control broadcast to every cell
    typedef struct packed {
        logic       eval;
        logic       sel;
        logic       is_free;
        logic [2:0] op;
    } cell_ctrl_t;

    // per-cell status towards the control
    typedef struct packed {
        logic at_p;
        logic hit_next;
        logic hit_prev;
    } cell_stat_t;

endpackage

@@ hw/rtl/ffa_item_if.sv @@
// input transaction channel of the allocator
interface ffa_item_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [SIZE_W-1:0] alloc_size;
    logic [REQ_W-1:0]  free_request;

    modport source (output valid, func, alloc_size, free_request, input ready);
    modport sink (input valid, func, alloc_size, free_request, output ready);
endinterface

@@ hw/rtl/ffa_result_if.sv @@
// result transaction channel of the allocator
interface ffa_result_if import ffa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_OUT_W-1:0] address;
    logic                  failed;

    modport source (output valid, address, failed, input ready);
    modport sink (input valid, address, failed, output ready);
endinterface

@@ hw/rtl/ffa_cfg_if.sv @@
// configuration write channel of the allocator
interface ffa_cfg_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/ffa_ram.sv @@
// generic single write port ram with registered read
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ffa_prefix.sv @@
// log-depth inclusive prefix or over the cell flags
module ffa_prefix #(
    parameter int N = 4
) (
    input  logic [N-1:0] a,
    output logic [N-1:0] y
);

    localparam int L = $clog2(N);

    logic [N-1:0] lvl [L+1];

    assign lvl[0] = a;

    // each level doubles the span covered
    for (genvar l = 0; l < L; l++)
    begin : g_lvl
        for (genvar i = 0; i < N; i++)
        begin : g_bit
            if (i >= (1 << l))
            begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
            end
            else
            begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign y = lvl[L];

endmodule

@@ hw/rtl/ffa_cell.sv @@
// one free-list cell: holds a block and updates from its neighbours
module ffa_cell import ffa_pkg::*; #(
    parameter int AW       = DEF_ADDR_BITS,
    parameter bit IS_FIRST = 1'b0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctrl_t    ctrl,
    input  logic [AW-1:0] opa,
    input  logic [AW-1:0] opb,
    input  logic          ge_in,
    input  logic          prev_ge,
    input  logic          next_ge,
    input  logic          prev_valid,
    input  logic [AW-1:0] prev_start,
    input  logic [AW-1:0] prev_size,
    input  logic          next_valid,
    input  logic [AW-1:0] next_start,
    input  logic [AW-1:0] next_size,
    output logic          flag,
    output logic          ge,
    output logic          valid,
    output logic [AW-1:0] start,
    output logic [AW-1:0] size,
    output cell_stat_t    stat,
    output logic [AW-1:0] sel_start,
    output logic [AW-1:0] sel_size
);

    logic          flag_reg, flag_next;
    logic          ge_reg;
    logic          valid_reg, valid_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] size_reg, size_next;
    logic          at_p, at_prev;

    // position of this cell relative to the chosen slot
    assign at_p    = ge_reg & ~prev_ge;
    assign at_prev = ~ge_reg & next_ge;

    // compare stage: fit test or lower-address test
    assign flag_next = ctrl.is_free ? (valid_reg & (start_reg < opa))
                                    : (valid_reg & (size_reg >= opa));

    // neighbour join tests for a free
    assign stat.at_p     = at_p;
    assign stat.hit_next = at_p & valid_reg &
                           (({1'b0, opa} + {1'b0, opb}) == {1'b0, start_reg});
    assign stat.hit_prev = at_prev & valid_reg &
                           (({1'b0, start_reg} + {1'b0, size_reg}) == {1'b0, opa});

    assign sel_start = at_p ? start_reg : '0;
    assign sel_size  = at_p ? size_reg : '0;

    // block update
    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        size_next  = size_reg;
        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_INIT:
            begin
                if (IS_FIRST)
                begin
                    start_next = AW'(1);
                    size_next  = opb;
                    valid_next = (opb != '0);
                end
                else
                begin
                    valid_next = 1'b0;
                end
            end
            OP_SHRINK:
            begin
                if (at_p)
                begin
                    start_next = start_reg + opa;
                    size_next  = size_reg - opa;
                end
            end
            OP_REMOVE:
            begin
                if (ge_reg)
                begin
                    valid_next = next_valid;
                    start_next = next_start;
                    size_next  = next_size;
                end
            end
            OP_MERGE_BOTH:
            begin
                if (at_prev)
                begin
                    size_next = size_reg + opb + next_size;
                end
                else if (ge_reg)
                begin
                    valid_next = next_valid;
                    start_next = next_start;
                    size_next  = next_size;
                end
            end
            OP_MERGE_PREV:
            begin
                if (at_prev)
                begin
                    size_next = size_reg + opb;
                end
            end
            OP_MERGE_NEXT:
            begin
                if (at_p)
                begin
                    start_next = opa;
                    size_next  = size_reg + opb;
                end
            end
            OP_INSERT:
            begin
                if (at_p)
                begin
                    valid_next = 1'b1;
                    start_next = opa;
                    size_next  = opb;
                end
                else if (ge_reg)
                begin
                    valid_next = prev_valid;
                    start_next = prev_start;
                    size_next  = prev_size;
                end
            end
        endcase
    end

    // cell registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            ge_reg    <= 1'b0;
            valid_reg <= IS_FIRST;
            start_reg <= AW'(1);
            size_reg  <= AW'(RESET_MEMORY_SIZE);
        end
        else
        begin
            if (ctrl.eval)
            begin
                flag_reg <= flag_next;
            end
            if (ctrl.sel)
            begin
                ge_reg <= ge_in;
            end
            valid_reg <= valid_next;
            start_reg <= start_next;
            size_reg  <= size_next;
        end
    end

    assign flag  = flag_reg;
    assign ge    = ge_reg;
    assign valid = valid_reg;
    assign start = start_reg;
    assign size  = size_reg;

endmodule

@@ hw/rtl/first_fit_allocator_coalescing_top.sv @@
// top level of the first-fit allocator with a coalescing free list
//
// The free list lives in a row of MAX_FREE_BLOCKS cells, one block per cell in
// address order; grants are kept in a MAX_REQUESTS deep ram. Each transaction
// passes through the acceptance cycle, which starts the grant ram read, a
// parallel compare in every cell, a prefix pick of the first matching cell, a
// reduction of the picked block and join tests, and the update in which the
// cells shift towards or away from their neighbours. The result is registered
// in the update and presented after it. A new input transaction is accepted
// only once the sequencer is back in idle, so transactions never overlap; the
// steps are set by the cell compare and priority path and the registered ram
// read. The update waits only while an earlier result is still held by the
// receiver. A memory_size write restarts the list as it is accepted; no clearing
// pass runs, since grants beyond the running request number count as empty.
module first_fit_allocator_coalescing_top import ffa_pkg::*; #(
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int MAX_REQUESTS    = DEF_MAX_REQUESTS,
    parameter int ADDR_BITS       = DEF_ADDR_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    ffa_item_if.sink      item_in,
    ffa_result_if.source  result_out,
    ffa_cfg_if.sink       cfg
);

    localparam int N     = MAX_FREE_BLOCKS;
    localparam int AW    = ADDR_BITS;
    localparam int FC_W  = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int RN_W  = $clog2(MAX_REQUESTS + 1);
    localparam int RA_W  = $clog2(MAX_REQUESTS);
    localparam int RAM_W = 2 * AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic                  func_reg;
    logic [SIZE_W-1:0]     asize_reg;
    logic [REQ_W-1:0]      k_reg;
    logic [RN_W-1:0]       rn_reg;
    logic [FC_W-1:0]       count_reg;
    logic [AW-1:0]         opa_reg, opb_reg;
    logic                  gok_reg, hist_full_reg, zero_reg;
    logic                  found_reg, jn_reg, jp_reg;
    logic [AW-1:0]         pick_start_reg, pick_size_reg;
    logic                  out_valid_reg, out_failed_reg;
    logic [ADDR_OUT_W-1:0] out_addr_reg;

    logic                  in_acc, cfg_acc, apply_go;
    logic [RA_W-1:0]       r_item, r_reg;
    logic                  k_ok;
    logic                  hist_full;
    logic [RAM_W-1:0]      ram_rdata, ram_wdata;
    logic                  ram_we;
    logic [RA_W-1:0]       ram_waddr;
    logic                  ram_r_valid;
    logic [AW-1:0]         ram_r_start, ram_r_size;
    logic [AW-1:0]         opa, opb, eval_opa;
    logic [2:0]            apply_op;
    logic                  produce, prod_failed;
    logic [ADDR_OUT_W-1:0] prod_addr;
    logic                  alloc_ok, free_ovf;
    cell_ctrl_t            ctrl;

    logic [N-1:0]          c_flag, c_ge, c_valid, pre, ge_in;
    logic [AW-1:0]         c_start [N];
    logic [AW-1:0]         c_size [N];
    logic [AW-1:0]         c_sel_start [N];
    logic [AW-1:0]         c_sel_size [N];
    cell_stat_t            c_stat [N];
    logic                  found_c, jn_c, jp_c;
    logic [AW-1:0]         pick_start_c, pick_size_c;

    // handshakes
    assign item_in.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready     = (state_reg == S_IDLE);
    assign in_acc        = item_in.valid && item_in.ready;
    assign cfg_acc       = cfg.valid && cfg.ready;
    assign apply_go      = (state_reg == S_APPLY) && !(out_valid_reg && !result_out.ready);

    // grant record lookup
    assign r_item    = RA_W'(item_in.free_request - REQ_W'(1));
    assign r_reg     = RA_W'(k_reg - REQ_W'(1));
    assign k_ok      = (k_reg != '0) && (32'(k_reg) <= 32'(MAX_REQUESTS));
    assign hist_full = (32'(rn_reg) >= 32'(MAX_REQUESTS));
    assign {ram_r_valid, ram_r_start, ram_r_size} = ram_rdata;

    ffa_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_REQUESTS)
    ) u_grants (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (r_item),
        .rdata (ram_rdata)
    );

    // operands broadcast to the cells
    assign eval_opa = func_reg ? ram_r_start : AW'(asize_reg);
    assign opa      = (state_reg == S_EVAL) ? eval_opa : opa_reg;
    assign opb      = cfg_acc ? AW'(cfg.data) : opb_reg;

    // decision of the update step
    assign alloc_ok = !zero_reg && found_reg;
    assign free_ovf = !jn_reg && !jp_reg && (32'(count_reg) >= 32'(N));

    always_comb
    begin
        apply_op    = OP_NONE;
        produce     = 1'b0;
        prod_failed = 1'b1;
        prod_addr   = '0;
        ram_we      = 1'b0;
        ram_waddr   = RA_W'(rn_reg);
        ram_wdata   = '0;
        if ((state_reg == S_EVAL) && !hist_full)
        begin
            ram_we = 1'b1;
        end
        else if (apply_go && !hist_full_reg)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                produce = 1'b1;
                if (alloc_ok)
                begin
                    prod_failed = 1'b0;
                    prod_addr   = ADDR_OUT_W'(pick_start_reg);
                    apply_op    = (pick_size_reg == AW'(asize_reg)) ? OP_REMOVE : OP_SHRINK;
                    ram_we      = 1'b1;
                    ram_wdata   = {1'b1, pick_start_reg, AW'(asize_reg)};
                end
            end
            else if (gok_reg)
            begin
                if (free_ovf)
                begin
                    produce = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = r_reg;
                    if (jn_reg && jp_reg)
                    begin
                        apply_op = OP_MERGE_BOTH;
                    end
                    else if (jp_reg)
                    begin
                        apply_op = OP_MERGE_PREV;
                    end
                    else if (jn_reg)
                    begin
                        apply_op = OP_MERGE_NEXT;
                    end
                    else
                    begin
                        apply_op = OP_INSERT;
                    end
                end
            end
        end
        else if (apply_go)
        begin
            produce = 1'b1;
        end
    end

    assign ctrl.eval    = (state_reg == S_EVAL);
    assign ctrl.sel     = (state_reg == S_SEL);
    assign ctrl.is_free = func_reg;
    assign ctrl.op      = cfg_acc ? OP_INIT : apply_op;

    // first-fit pick across the chain
    ffa_prefix #(
        .N (N)
    ) u_prefix (
        .a (c_flag),
        .y (pre)
    );

    assign ge_in = func_reg ? ~c_flag : pre;

    // the cell row
    for (genvar j = 0; j < N; j++)
    begin : g_cell
        logic          p_ge, n_ge, p_valid, n_valid;
        logic [AW-1:0] p_start, p_size, n_start, n_size;

        if (j == 0)
        begin : g_head
            assign p_ge    = 1'b0;
            assign p_valid = 1'b0;
            assign p_start = '0;
            assign p_size  = '0;
        end
        else
        begin : g_body
            assign p_ge    = c_ge[j-1];
            assign p_valid = c_valid[j-1];
            assign p_start = c_start[j-1];
            assign p_size  = c_size[j-1];
        end

        if (j == N - 1)
        begin : g_tail
            assign n_ge    = 1'b1;
            assign n_valid = 1'b0;
            assign n_start = '0;
            assign n_size  = '0;
        end
        else
        begin : g_link
            assign n_ge    = c_ge[j+1];
            assign n_valid = c_valid[j+1];
            assign n_start = c_start[j+1];
            assign n_size  = c_size[j+1];
        end

        ffa_cell #(
            .AW       (AW),
            .IS_FIRST (j == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .opa        (opa),
            .opb        (opb),
            .ge_in      (ge_in[j]),
            .prev_ge    (p_ge),
            .next_ge    (n_ge),
            .prev_valid (p_valid),
            .prev_start (p_start),
            .prev_size  (p_size),
            .next_valid (n_valid),
            .next_start (n_start),
            .next_size  (n_size),
            .flag       (c_flag[j]),
            .ge         (c_ge[j]),
            .valid      (c_valid[j]),
            .start      (c_start[j]),
            .size       (c_size[j]),
            .stat       (c_stat[j]),
            .sel_start  (c_sel_start[j]),
            .sel_size   (c_sel_size[j])
        );
    end

    // or-reduction of the picked block and join tests
    always_comb
    begin
        found_c      = 1'b0;
        jn_c         = 1'b0;
        jp_c         = 1'b0;
        pick_start_c = '0;
        pick_size_c  = '0;
        for (int j = 0; j < N; j++)
        begin
            found_c      = found_c | c_stat[j].at_p;
            jn_c         = jn_c | c_stat[j].hit_next;
            jp_c         = jp_c | c_stat[j].hit_prev;
            pick_start_c = pick_start_c | c_sel_start[j];
            pick_size_c  = pick_size_c | c_sel_size[j];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:  state_next = S_SEL;
            S_SEL:   state_next = S_PICK;
            S_PICK:  state_next = S_APPLY;
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rn_reg        <= '0;
            count_reg     <= FC_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                rn_reg    <= '0;
                count_reg <= (cfg.data != '0) ? FC_W'(1) : '0;
            end
            else if (apply_go && !hist_full_reg)
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    rn_reg <= rn_reg + RN_W'(1);
                    if (alloc_ok && (pick_size_reg == AW'(asize_reg)))
                    begin
                        count_reg <= count_reg - FC_W'(1);
                    end
                end
                else if (!gok_reg)
                begin
                    rn_reg <= rn_reg + RN_W'(1);
                end
                else if (!free_ovf)
                begin
                    rn_reg <= rn_reg + RN_W'(1);
                    if (jn_reg && jp_reg)
                    begin
                        count_reg <= count_reg - FC_W'(1);
                    end
                    else if (!jn_reg && !jp_reg)
                    begin
                        count_reg <= count_reg + FC_W'(1);
                    end
                end
            end
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg  <= item_in.func;
            asize_reg <= item_in.alloc_size;
            k_reg     <= item_in.free_request;
        end
        if (state_reg == S_EVAL)
        begin
            opa_reg       <= eval_opa;
            opb_reg       <= ram_r_size;
            hist_full_reg <= hist_full;
            zero_reg      <= (asize_reg == '0);
            gok_reg       <= k_ok && ram_r_valid && (RN_W'(r_reg) < rn_reg);
        end
        if (state_reg == S_PICK)
        begin
            found_reg      <= found_c;
            jn_reg         <= jn_c;
            jp_reg         <= jp_c;
            pick_start_reg <= pick_start_c;
            pick_size_reg  <= pick_size_c;
        end
        if (produce)
        begin
            out_addr_reg   <= prod_addr;
            out_failed_reg <= prod_failed;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.address = out_addr_reg;
    assign result_out.failed  = out_failed_reg;

    // checks
    a_rn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rn_reg) <= 32'(MAX_REQUESTS))
        else $error("request number beyond history depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(N))
        else $error("free block count beyond cell row");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_APPLY)
        else $error("result raised outside the update step");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (rn_reg == '0) && (state_reg == S_IDLE))
        else $error("restart did not clear the request number");

endmodule
